>>> hw/rtl/tc_pkg.sv
// Shared constants and types for the threshold centroid block.
package tc_pkg;

  // Default frame limits
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  // Fixed field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned FW_W   = 12;
  localparam int unsigned FH_W   = 12;
  localparam int unsigned WSUM_W = 30;
  localparam int unsigned CEN_W  = 19;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register reset values
  localparam logic [PIX_W-1:0] THRESHOLD_RST    = 8'd128;
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 12'd480;

  // Saturation limits and marked pixel value
  localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
  localparam logic [CEN_W-1:0]  CEN_MAX  = '1;
  localparam logic [PIX_W-1:0]  PIX_MARK = '1;

  // Result kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Register index (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XGO,
    ST_XWAIT,
    ST_YWAIT,
    ST_SUM
  } state_e;

endpackage

>>> hw/rtl/tc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module tc_div #(
  parameter int unsigned DW = 42,
  parameter int unsigned VW = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    quot_q, quot_d;
  logic [VW-1:0]    dvs_q, dvs_d;

  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             fits;

  // Trial subtract: shift in next dividend bit
  assign trial = {rem_q, quot_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  // Step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[VW-1:0] : trial[VW-1:0];
      quot_d = {quot_q[DW-2:0], fits};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a running division");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < CNT_W'(DW))
    else $error("divider step count out of range");

endmodule

>>> hw/rtl/threshold_centroid.sv
// Top level: binarize a pixel stream and compute per-frame centroids.
//
// Pixels are taken in raster order, one word per cycle while the result side keeps up; each
// gives one binarized word out. The last pixel of a frame starts two serial divisions on one
// shared restoring divider (x then y), with DW = sum width + 8 (42 at the default 2048x2048
// limits), and the frame summary word is loaded once both are done; no pixel is taken
// until it has been loaded. An unusable frame width turns each pixel into a single summary
// word with width_error set and restarts the frame. Registers: threshold at 0x0,
// frame_width at 0x4, frame_height at 0x8.
module threshold_centroid #(
  parameter int unsigned MAX_WIDTH  = tc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = tc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tc_pkg::ADDR_W-1:0]   paddr,
  input  logic [tc_pkg::DATA_W-1:0]   pwdata,
  output logic [tc_pkg::DATA_W-1:0]   prdata,
  output logic                        pready,
  // pixel input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tc_pkg::PIX_W-1:0]    pixel_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [tc_pkg::PIX_W-1:0]    pixel_out_o,
  output logic [tc_pkg::WSUM_W-1:0]   weight_sum_o,
  output logic [tc_pkg::CEN_W-1:0]    centroid_x_o,
  output logic [tc_pkg::CEN_W-1:0]    centroid_y_o,
  output logic                        centroid_valid_o,
  output logic                        width_error_o,
  output logic                        last_o
);

  import tc_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned PW   = (CW > RW) ? CW : RW;
  localparam int unsigned CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SUMW = PW + CNTW;
  localparam int unsigned DW   = SUMW + 8;
  localparam int unsigned WSW  = CNTW + 8;
  localparam int unsigned CMPW = ((PW > FW_W) ? PW : FW_W) + 1;

  // Configuration registers
  logic [PIX_W-1:0] threshold_q;
  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic             cfg_wr;

  // Frame state
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CNTW-1:0]  marked_q, marked_d;
  logic [SUMW-1:0]  csum_q, csum_d;
  logic [SUMW-1:0]  rsum_q, rsum_d;
  logic [CEN_W-1:0] cx_q, cy_q;

  state_e           state_q, state_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             kind_q;
  logic [PIX_W-1:0] pix_q;
  logic [WSUM_W-1:0] ws_q;
  logic [CEN_W-1:0] ocx_q, ocy_q;
  logic             cval_q, werr_q, last_q;

  // Control
  logic             in_acc;
  logic             out_free;
  logic             sum_load;
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [DW-1:0]    div_dividend;
  logic [DW-1:0]    div_quot;
  logic [CEN_W-1:0] cen_sat;

  // Per-pixel decode
  logic [CMPW-1:0]  fw_ext, fh_ext, h_eff;
  logic             width_bad, row_end, frame_end, marked;
  logic [WSW-1:0]   ws_full;
  logic [WSUM_W-1:0] ws_sat;
  logic             cnt_nz;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= THRESHOLD_RST;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        REG_THRESHOLD:    threshold_q    <= pwdata[PIX_W-1:0];
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_THRESHOLD:    prdata = DATA_W'(threshold_q);
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------- pixel decode ----------------
  assign fw_ext    = CMPW'(frame_width_q);
  assign fh_ext    = CMPW'(frame_height_q);
  assign width_bad = (frame_width_q == '0) || (frame_width_q[2:0] != 3'd0) ||
                     (fw_ext > CMPW'(MAX_WIDTH));

  // Zero height acts as one, oversize height clamps to the limit
  always_comb begin
    if (frame_height_q == '0) begin
      h_eff = CMPW'(1);
    end else if (fh_ext > CMPW'(MAX_HEIGHT)) begin
      h_eff = CMPW'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext;
    end
  end

  assign row_end   = (CMPW'(col_q) + CMPW'(1)) >= fw_ext;
  assign frame_end = row_end && ((CMPW'(row_q) + CMPW'(1)) >= h_eff);
  assign marked    = pixel_i <= threshold_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && !width_bad && frame_end) state_d = ST_XGO;
      ST_XGO:   state_d = ST_XWAIT;
      ST_XWAIT: if (div_done) state_d = ST_YWAIT;
      ST_YWAIT: if (div_done) state_d = ST_SUM;
      ST_SUM:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = !((state_q == ST_IDLE) && out_free);
    div_start  = (state_q == ST_XGO) || ((state_q == ST_XWAIT) && div_done);
    sum_load   = (state_q == ST_SUM) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- frame accumulators ----------------
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    marked_d = marked_q;
    csum_d   = csum_q;
    rsum_d   = rsum_q;
    if (in_acc) begin
      if (width_bad) begin
        col_d    = '0;
        row_d    = '0;
        marked_d = '0;
        csum_d   = '0;
        rsum_d   = '0;
      end else begin
        if (marked) begin
          marked_d = marked_q + CNTW'(1);
          csum_d   = csum_q + SUMW'(col_q);
          rsum_d   = rsum_q + SUMW'(row_q);
        end
        if (!row_end) begin
          col_d = col_q + CW'(1);
        end else begin
          col_d = '0;
          row_d = frame_end ? '0 : row_q + RW'(1);
        end
      end
    end else if (sum_load) begin
      marked_d = '0;
      csum_d   = '0;
      rsum_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      marked_q <= '0;
      csum_q   <= '0;
      rsum_q   <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      marked_q <= marked_d;
      csum_q   <= csum_d;
      rsum_q   <= rsum_d;
    end
  end

  // ---------------- shared divider ----------------
  assign div_dividend = (state_q == ST_XGO) ? {csum_q, 8'd0} : {rsum_q, 8'd0};

  tc_div #(
    .DW (DW),
    .VW (CNTW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (marked_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Clamp quotient to the centroid field
  assign cen_sat = (div_quot > DW'(CEN_MAX)) ? CEN_MAX : CEN_W'(div_quot);

  always_ff @(posedge clk_i) begin
    if (div_done && (state_q == ST_XWAIT)) cx_q <= cen_sat;
    if (div_done && (state_q == ST_YWAIT)) cy_q <= cen_sat;
  end

  // Weight sum = 255 * count, saturated
  assign ws_full = {marked_q, 8'd0} - WSW'(marked_q);
  assign ws_sat  = (ws_full > WSW'(WSUM_MAX)) ? WSUM_MAX : WSUM_W'(ws_full);
  assign cnt_nz  = marked_q != '0;

  // ---------------- output register ----------------
  always_comb begin
    if (in_acc || sum_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q  <= '0;
      ws_q   <= '0;
      ocx_q  <= '0;
      ocy_q  <= '0;
      cval_q <= 1'b0;
      if (width_bad) begin
        kind_q <= KIND_SUMMARY;
        werr_q <= 1'b1;
        last_q <= 1'b1;
      end else begin
        kind_q <= KIND_PIXEL;
        pix_q  <= marked ? PIX_MARK : '0;
        werr_q <= 1'b0;
        last_q <= !frame_end;
      end
    end else if (sum_load) begin
      kind_q <= KIND_SUMMARY;
      pix_q  <= '0;
      ws_q   <= ws_sat;
      ocx_q  <= cnt_nz ? cx_q : '0;
      ocy_q  <= cnt_nz ? cy_q : '0;
      cval_q <= cnt_nz;
      werr_q <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign pixel_out_o      = pix_q;
  assign weight_sum_o     = ws_q;
  assign centroid_x_o     = ocx_q;
  assign centroid_y_o     = ocy_q;
  assign centroid_valid_o = cval_q;
  assign width_error_o    = werr_q;
  assign last_o           = last_q;

  // ---------------- checks ----------------
  a_frame_end_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !width_bad && frame_end |=> state_q == ST_XGO)
    else $error("frame end did not start the centroid division");

  a_werr_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && width_error_o |-> (kind_o == KIND_SUMMARY) && last_o)
    else $error("width error word is not a final summary");

  a_empty_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_SUMMARY) && !centroid_valid_o |->
      (centroid_x_o == '0) && (centroid_y_o == '0) && (weight_sum_o == '0))
    else $error("empty frame summary carries nonzero fields");

  a_sum_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |-> !div_busy)
    else $error("summary pending while divider still busy");

endmodule

>>> verif/tc_stream_check.sv
// Stream checker for threshold_centroid: predicts every result word and compares it.
module tc_stream_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port, observed
  input  logic                        apb_psel_i,
  input  logic                        apb_penable_i,
  input  logic                        apb_pwrite_i,
  input  logic                        apb_pready_i,
  input  logic [tc_pkg::ADDR_W-1:0]   apb_paddr_i,
  input  logic [tc_pkg::DATA_W-1:0]   apb_pwdata_i,
  // pixel channel
  input  logic                        pix_valid_i,
  input  logic                        pix_stall_i,
  input  logic [tc_pkg::PIX_W-1:0]    pixel_i,
  // result channel
  input  logic                        res_valid_i,
  input  logic                        res_stall_i,
  input  logic                        kind_i,
  input  logic [tc_pkg::PIX_W-1:0]    pixel_out_i,
  input  logic [tc_pkg::WSUM_W-1:0]   weight_sum_i,
  input  logic [tc_pkg::CEN_W-1:0]    centroid_x_i,
  input  logic [tc_pkg::CEN_W-1:0]    centroid_y_i,
  input  logic                        centroid_valid_i,
  input  logic                        width_error_i,
  input  logic                        last_i,
  // status to the top
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  import tc_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [PIX_W-1:0]  pix;
    logic [WSUM_W-1:0] wsum;
    logic [CEN_W-1:0]  cx;
    logic [CEN_W-1:0]  cy;
    logic              cvalid;
    logic              werr;
    logic              last;
  } tc_word_t;

  // register copies
  bit [PIX_W-1:0] thr;
  bit [FW_W-1:0]  fwidth;
  bit [FH_W-1:0]  fheight;

  // frame accumulators
  bit [11:0] col_pos;
  bit [11:0] row_pos;
  bit [22:0] mark_cnt;
  bit [33:0] col_sum;
  bit [33:0] row_sum;

  tc_word_t frame_words_q[$];

  task automatic clear_frame();
    col_pos  = '0;
    row_pos  = '0;
    mark_cnt = '0;
    col_sum  = '0;
    row_sum  = '0;
  endtask

  // mean index with 8 fraction bits, truncated and clipped
  function automatic logic [CEN_W-1:0] mean_pos(input bit [33:0] sum, input bit [22:0] cnt);
    bit [41:0] q;
    if (cnt == 0) return '0;
    q = {sum, 8'd0} / {19'd0, cnt};
    if (q > {23'd0, CEN_MAX}) return CEN_MAX;
    return q[CEN_W-1:0];
  endfunction

  // binarize one pixel, update sums, and emit the summary at frame end
  task automatic binarize_and_accumulate(input logic [PIX_W-1:0] pix);
    tc_word_t  w;
    tc_word_t  s;
    int        rows;
    bit        hit;
    bit        row_done;
    bit        frame_done;
    bit [30:0] ws;
    w = '0;
    s = '0;
    if (fwidth == 0 || fwidth[2:0] != 3'd0 || fwidth > MAX_WIDTH_DEF) begin
      // unusable width: lone error summary, frame restarts
      w.kind = KIND_SUMMARY;
      w.werr = 1'b1;
      w.last = 1'b1;
      frame_words_q.push_back(w);
      clear_frame();
    end else begin
      rows = (fheight == 0) ? 1 : (fheight > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : int'(fheight));
      hit = (pix <= thr);
      if (hit) begin
        mark_cnt = mark_cnt + 23'd1;
        col_sum  = col_sum + 34'(col_pos);
        row_sum  = row_sum + 34'(row_pos);
      end
      row_done   = (int'(col_pos) + 1 >= int'(fwidth));
      frame_done = row_done && (int'(row_pos) + 1 >= rows);
      w.kind = KIND_PIXEL;
      w.pix  = hit ? PIX_MARK : '0;
      w.last = !frame_done;
      frame_words_q.push_back(w);
      if (!row_done) begin
        col_pos = col_pos + 12'd1;
      end else if (!frame_done) begin
        col_pos = '0;
        row_pos = row_pos + 12'd1;
      end else begin
        ws = 31'(mark_cnt) * 31'd255;
        if (ws > {1'b0, WSUM_MAX}) ws = {1'b0, WSUM_MAX};
        s.kind   = KIND_SUMMARY;
        s.wsum   = ws[WSUM_W-1:0];
        s.cx     = mean_pos(col_sum, mark_cnt);
        s.cy     = mean_pos(row_sum, mark_cnt);
        s.cvalid = (mark_cnt != 0);
        s.last   = 1'b1;
        frame_words_q.push_back(s);
        clear_frame();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t check: %s got %0h want %0h", $time, what, got, want);
    fail_count_o = fail_count_o + 1;
  endtask

  // compare an accepted word against the oldest prediction
  task automatic compare_word();
    tc_word_t w;
    if (frame_words_q.size() == 0) begin
      report_mismatch("unexpected word kind", 32'(kind_i), 32'hx);
    end else begin
      w = frame_words_q.pop_front();
      if (kind_i !== w.kind)            report_mismatch("kind", 32'(kind_i), 32'(w.kind));
      if (pixel_out_i !== w.pix)        report_mismatch("pixel_out", 32'(pixel_out_i), 32'(w.pix));
      if (weight_sum_i !== w.wsum)      report_mismatch("weight_sum", 32'(weight_sum_i),
                                                        32'(w.wsum));
      if (centroid_x_i !== w.cx)        report_mismatch("centroid_x", 32'(centroid_x_i),
                                                        32'(w.cx));
      if (centroid_y_i !== w.cy)        report_mismatch("centroid_y", 32'(centroid_y_i),
                                                        32'(w.cy));
      if (centroid_valid_i !== w.cvalid) report_mismatch("centroid_valid",
                                                         32'(centroid_valid_i), 32'(w.cvalid));
      if (width_error_i !== w.werr)     report_mismatch("width_error", 32'(width_error_i),
                                                        32'(w.werr));
      if (last_i !== w.last)            report_mismatch("last", 32'(last_i), 32'(w.last));
    end
  endtask

  // predictions go in before the compare, so a same-cycle word still finds its entry
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr     = THRESHOLD_RST;
      fwidth  = FRAME_WIDTH_RST;
      fheight = FRAME_HEIGHT_RST;
      clear_frame();
      frame_words_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (apb_psel_i && apb_penable_i && apb_pwrite_i && apb_pready_i) begin
        case (cfg_reg_e'(apb_paddr_i[3:2]))
          REG_THRESHOLD:    thr     = apb_pwdata_i[PIX_W-1:0];
          REG_FRAME_WIDTH:  fwidth  = apb_pwdata_i[FW_W-1:0];
          REG_FRAME_HEIGHT: fheight = apb_pwdata_i[FH_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid_i && !pix_stall_i) binarize_and_accumulate(pixel_i);
      if (res_valid_i && !res_stall_i) compare_word();
      pending_o = frame_words_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top for threshold_centroid: clock, reset, stimulus and verdict.
module tb;
  import tc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PIX_W-1:0]    pixel_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                kind_o;
  logic [PIX_W-1:0]    pixel_out_o;
  logic [WSUM_W-1:0]   weight_sum_o;
  logic [CEN_W-1:0]    centroid_x_o;
  logic [CEN_W-1:0]    centroid_y_o;
  logic                centroid_valid_o;
  logic                width_error_o;
  logic                last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  bit          gap_on   = 1'b1;
  bit          stall_on = 1'b1;
  bit          hold_req = 1'b0;

  threshold_centroid dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_i          (pixel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .pixel_out_o      (pixel_out_o),
    .weight_sum_o     (weight_sum_o),
    .centroid_x_o     (centroid_x_o),
    .centroid_y_o     (centroid_y_o),
    .centroid_valid_o (centroid_valid_o),
    .width_error_o    (width_error_o),
    .last_o           (last_o)
  );

  tc_stream_check check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .apb_psel_i       (psel),
    .apb_penable_i    (penable),
    .apb_pwrite_i     (pwrite),
    .apb_pready_i     (pready),
    .apb_paddr_i      (paddr),
    .apb_pwdata_i     (pwdata),
    .pix_valid_i      (in_valid_i),
    .pix_stall_i      (in_stall_o),
    .pixel_i          (pixel_i),
    .res_valid_i      (out_valid_o),
    .res_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .pixel_out_i      (pixel_out_o),
    .weight_sum_i     (weight_sum_o),
    .centroid_x_i     (centroid_x_o),
    .centroid_y_i     (centroid_y_o),
    .centroid_valid_i (centroid_valid_o),
    .width_error_i    (width_error_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 10-unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // offer one pixel word, possibly after a gap, and wait for it to be taken
  task automatic push_pixel(input logic [PIX_W-1:0] value);
    if (gap_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pixel_i    = value;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // APB write; bits above the register width carry noise
  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] keep;
    keep    = (idx == REG_THRESHOLD) ? 32'h0000_00FF : 32'h0000_0FFF;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = (32'($urandom) & ~keep) | (value & keep);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // stop offering and let every predicted word drain
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [PIX_W-1:0] thr, input logic [FW_W-1:0] wid,
                           input logic [FH_W-1:0] hgt);
    settle();
    write_reg(REG_THRESHOLD, 32'(thr));
    write_reg(REG_FRAME_WIDTH, 32'(wid));
    write_reg(REG_FRAME_HEIGHT, 32'(hgt));
  endtask

  // pixel values biased toward the threshold edge and the range ends
  function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] thr);
    case ($urandom_range(0, 5))
      0:       return thr;
      1:       return thr + 8'd1;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int               sent;
    int               count;
    int               pick;
    int               rows;
    logic [PIX_W-1:0] thr;
    logic [FW_W-1:0]  wid;
    logic [FH_W-1:0]  hgt;

    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    pixel_i    = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset threshold boundary, then narrow the frame mid-row
    push_pixel(8'd128);
    push_pixel(8'd129);
    settle();
    write_reg(REG_FRAME_WIDTH, 32'd8);
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd127);
    push_pixel(8'd128);
    push_pixel(8'd129);
    push_pixel(8'd1);

    // threshold at top: every pixel marked
    set_frame(8'd255, 12'd8, 12'd1);
    repeat (8) push_pixel(8'hFF);

    // threshold at bottom, height zero acting as one row: nothing marked
    set_frame(8'd0, 12'd8, 12'd0);
    repeat (8) push_pixel(8'($urandom_range(1, 255)));

    // unusable widths: not a multiple of eight, zero, above the limit
    set_frame(8'd128, 12'd12, 12'd1);
    push_pixel(8'd0);
    push_pixel(8'd200);
    settle();
    write_reg(REG_FRAME_WIDTH, 32'd0);
    push_pixel(8'd5);
    settle();
    write_reg(REG_FRAME_WIDTH, 32'd2056);
    push_pixel(8'd5);

    // one 256-pixel row while the result side holds off for a long stretch
    thr = 8'($urandom_range(64, 192));
    set_frame(thr, 12'd256, 12'd1);
    hold_req = 1'b1;
    repeat (256) push_pixel(pick_pixel(thr));

    // random frames, mostly small and well formed
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        default: thr = 8'($urandom);
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        case ($urandom_range(0, 3))
          0:       wid = 12'd0;
          1:       wid = 12'hFFF;
          2:       wid = 12'd2056;
          default: wid = 12'($urandom_range(0, 4095)) | 12'd1;
        endcase
        hgt   = 12'($urandom_range(1, 4));
        count = $urandom_range(1, 6);
      end else if (pick == 1 || pick == 2) begin
        // tall frames, cut short; the next setting ends them
        wid = 12'(8 * $urandom_range(1, 4));
        if (pick == 1) hgt = 12'd2048;
        else hgt = $urandom_range(0, 1) ? 12'd2049 : 12'hFFF;
        count = int'(wid) * $urandom_range(1, 6);
      end else if (pick == 3) begin
        // widest rows, partial; the next setting narrows them
        wid   = 12'd2048;
        hgt   = 12'($urandom_range(1, 4));
        count = $urandom_range(1, 64);
      end else begin
        wid   = 12'(8 * $urandom_range(1, 8));
        hgt   = 12'($urandom_range(0, 4));
        rows  = (hgt == 0) ? 1 : int'(hgt);
        count = $urandom_range(1, 3) * int'(wid) * rows;
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      end
      set_frame(thr, wid, hgt);
      if (sent >= RANDOM_ITEMS * 4 / 5) begin
        gap_on   = 1'b0;
        stall_on = 1'b0;
      end else begin
        gap_on   = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      repeat (count) push_pixel(pick_pixel(thr));
      sent += count;
    end

    // drain, allow for a trailing summary, then the verdict
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tc_pkg.sv
hw/rtl/tc_div.sv
hw/rtl/threshold_centroid.sv
verif/tc_stream_check.sv
verif/tb.sv
